/* sv/ssq_pkg.sv */
// Shared types and constants for the session handshake sequencer.
// Holds the word formats, configuration struct and message codes.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ssq_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_HELLO_RETRY    = 3'd0;
  localparam logic [2:0] REG_RESOURCE_RETRY = 3'd1;
  localparam logic [2:0] REG_HEARTBEAT      = 3'd2;
  localparam logic [2:0] REG_RESP_TIMEOUT   = 3'd3;
  localparam logic [2:0] REG_RESOURCES      = 3'd4;

  // register reset values
  localparam logic [15:0] HELLO_RETRY_RST    = 16'd200;
  localparam logic [15:0] RESOURCE_RETRY_RST = 16'd300;
  localparam logic [15:0] HEARTBEAT_RST      = 16'd1000;
  localparam logic [15:0] RESP_TIMEOUT_RST   = 16'd2000;
  localparam logic [2:0]  RESOURCES_RST      = 3'd7;
  localparam logic [2:0]  ALL_RESOURCES      = 3'd7;

  // request types
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_MSG  = 1'b1;

  // message classes (codes 6 and 7 behave as other)
  localparam logic [2:0] MSG_SYS        = 3'd0;
  localparam logic [2:0] MSG_ACK        = 3'd1;
  localparam logic [2:0] MSG_NACK       = 3'd2;
  localparam logic [2:0] MSG_STATUS     = 3'd3;
  localparam logic [2:0] MSG_EN_KNOWN   = 3'd4;
  localparam logic [2:0] MSG_EN_UNKNOWN = 3'd5;

  // system message subtypes
  localparam logic [1:0] SYS_HELLO_ACK   = 2'd0;
  localparam logic [1:0] SYS_MODEL_READY = 2'd1;

  // acknowledge kinds and codes
  localparam logic [1:0] ACK_KIND_CMD = 2'd0;
  localparam logic [1:0] ACK_KIND_SYS = 2'd1;

  localparam logic [2:0] ACK_CONFIG  = 3'd0;
  localparam logic [2:0] ACK_BIND    = 3'd1;
  localparam logic [2:0] ACK_STREAM  = 3'd2;
  localparam logic [2:0] ACK_SESSION = 3'd3;

  // outgoing message kinds
  localparam logic [2:0] SEND_NONE      = 3'd0;
  localparam logic [2:0] SEND_GREETING  = 3'd1;
  localparam logic [2:0] SEND_RESOURCE  = 3'd2;
  localparam logic [2:0] SEND_CONFIG    = 3'd3;
  localparam logic [2:0] SEND_BIND      = 3'd4;
  localparam logic [2:0] SEND_STREAM    = 3'd5;
  localparam logic [2:0] SEND_SESSION   = 3'd6;
  localparam logic [2:0] SEND_KEEPALIVE = 3'd7;

  // configuration registers as seen by the sequencer
  typedef struct packed {
    logic [15:0] hello_retry_ms;
    logic [15:0] resource_retry_ms;
    logic [15:0] heartbeat_ms;
    logic [15:0] response_timeout_ms;
    logic [2:0]  resources_present;
  } cfg_t;

  // one input word
  typedef struct packed {
    logic        req_type;
    logic [31:0] time_ms;
    logic [2:0]  msg_class;
    logic [7:0]  msg_session;
    logic [1:0]  sys_subtype;
    logic [1:0]  ack_kind;
    logic [2:0]  ack_code;
    logic        ack_ok;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic [2:0] send_kind;
    logic [7:0] session_out;
    logic [7:0] beat_seq_out;
    logic       warm_reset_req;
    logic       media_enable_pulse;
    logic       forward_overlay;
    logic       overlay_clear;
    logic [2:0] fsm_state_out;
    logic       session_live;
  } result_t;

endpackage

`default_nettype wire

/* sv/ssq_cfg.sv */
// Configuration register file for the session handshake sequencer.
// Plain write port, no read-back; depends on ssq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssq_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_wdata,
  output ssq_pkg::cfg_t      cfg
);

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hello_retry_ms      <= ssq_pkg::HELLO_RETRY_RST;
      cfg.resource_retry_ms   <= ssq_pkg::RESOURCE_RETRY_RST;
      cfg.heartbeat_ms        <= ssq_pkg::HEARTBEAT_RST;
      cfg.response_timeout_ms <= ssq_pkg::RESP_TIMEOUT_RST;
      cfg.resources_present   <= ssq_pkg::RESOURCES_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ssq_pkg::REG_HELLO_RETRY:    cfg.hello_retry_ms      <= cfg_wdata;
        ssq_pkg::REG_RESOURCE_RETRY: cfg.resource_retry_ms   <= cfg_wdata;
        ssq_pkg::REG_HEARTBEAT:      cfg.heartbeat_ms        <= cfg_wdata;
        ssq_pkg::REG_RESP_TIMEOUT:   cfg.response_timeout_ms <= cfg_wdata;
        ssq_pkg::REG_RESOURCES:      cfg.resources_present   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/ssq_fsm.sv */
// Session state machine: holds the session state and computes one result
// per word from the registered input word. Depends on ssq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssq_fsm (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ssq_pkg::cfg_t      cfg,
  input  wire logic               step_en,
  input  wire ssq_pkg::in_word_t  item,
  output ssq_pkg::result_t        result
);

  typedef enum logic [2:0] {
    ST_RESET       = 3'd0,
    ST_HANDSHAKING = 3'd1,
    ST_DSP_READY   = 3'd2,
    ST_RES_READY   = 3'd3,
    ST_CONFIGURED  = 3'd4,
    ST_RUNNING     = 3'd5,
    ST_ERROR       = 3'd6
  } state_t;

  typedef enum logic [2:0] {
    PEND_NONE    = 3'd0,
    PEND_CONFIG  = 3'd1,
    PEND_BIND    = 3'd2,
    PEND_STREAM  = 3'd3,
    PEND_SESSION = 3'd4
  } pend_t;

  state_t      state, state_next;
  pend_t       pending, pending_next;
  logic [7:0]  session_number, session_number_next;
  logic [7:0]  beat_seq, beat_seq_next;
  logic [31:0] entered_ms, entered_ms_next;
  logic [31:0] last_hello_ms, last_hello_ms_next;
  logic [31:0] last_resource_ms, last_resource_ms_next;
  logic [31:0] last_beat_ms, last_beat_ms_next;
  logic        started, started_next;

  logic        all_res;
  logic        go;
  state_t      go_target;
  logic [31:0] now;

  assign now     = item.time_ms;
  assign all_res = (cfg.resources_present & ssq_pkg::ALL_RESOURCES) == ssq_pkg::ALL_RESOURCES;

  // next state and result for the current word
  always_comb begin
    state_next            = state;
    pending_next          = pending;
    session_number_next   = session_number;
    beat_seq_next         = beat_seq;
    entered_ms_next       = entered_ms;
    last_hello_ms_next    = last_hello_ms;
    last_resource_ms_next = last_resource_ms;
    last_beat_ms_next     = last_beat_ms;
    started_next          = started;
    go                    = 1'b0;
    go_target             = state;
    result                = '0;

    if (item.req_type == ssq_pkg::REQ_TICK) begin
      // timer tick: per-state action
      case (state)
        ST_RESET: begin
          session_number_next   = 8'(session_number + 8'd1);
          result.overlay_clear  = 1'b1;
          result.warm_reset_req = 1'b1;
          pending_next          = PEND_NONE;
          started_next          = 1'b0;
          result.send_kind      = ssq_pkg::SEND_GREETING;
          last_hello_ms_next    = now;
          state_next            = ST_HANDSHAKING;
          entered_ms_next       = now;
        end
        ST_HANDSHAKING: begin
          if (32'(now - last_hello_ms) >= {16'd0, cfg.hello_retry_ms}) begin
            result.send_kind   = ssq_pkg::SEND_GREETING;
            last_hello_ms_next = now;
          end
        end
        ST_RES_READY: begin
          if (32'(now - last_resource_ms) >= {16'd0, cfg.resource_retry_ms} &&
              pending == PEND_NONE && all_res) begin
            result.send_kind      = ssq_pkg::SEND_RESOURCE;
            last_resource_ms_next = now;
          end
        end
        ST_RUNNING: begin
          if (32'(now - last_beat_ms) >= {16'd0, cfg.heartbeat_ms}) begin
            result.send_kind    = ssq_pkg::SEND_KEEPALIVE;
            result.beat_seq_out = beat_seq;
            beat_seq_next       = 8'(beat_seq + 8'd1);
            last_beat_ms_next   = now;
          end
        end
        default: ;
      endcase

      // response timeout, checked against the state after the action
      if (state_next != ST_RUNNING && state_next != ST_RESET &&
          32'(now - entered_ms_next) >= {16'd0, cfg.response_timeout_ms}) begin
        state_next           = ST_RESET;
        entered_ms_next      = now;
        result.overlay_clear = 1'b1;
      end
    end else begin
      // received message
      case (item.msg_class)
        ssq_pkg::MSG_EN_KNOWN: begin
          if ((state inside {ST_CONFIGURED, ST_RUNNING}) && all_res)
            result.media_enable_pulse = 1'b1;
        end
        ssq_pkg::MSG_EN_UNKNOWN: ;
        ssq_pkg::MSG_SYS, ssq_pkg::MSG_ACK, ssq_pkg::MSG_NACK, ssq_pkg::MSG_STATUS: begin
          if (item.msg_session == session_number) begin
            case (item.msg_class)
              ssq_pkg::MSG_SYS: begin
                if (item.sys_subtype == ssq_pkg::SYS_HELLO_ACK) begin
                  // skips dsp ready and goes straight to resource ready
                  if (state inside {ST_HANDSHAKING, ST_RESET}) begin
                    state_next           = ST_RES_READY;
                    entered_ms_next      = now;
                    result.overlay_clear = 1'b1;
                    if (all_res) begin
                      result.send_kind      = ssq_pkg::SEND_RESOURCE;
                      last_resource_ms_next = now;
                    end
                  end
                end else if (item.sys_subtype == ssq_pkg::SYS_MODEL_READY) begin
                  if (state == ST_RES_READY && pending == PEND_NONE) begin
                    result.send_kind = ssq_pkg::SEND_CONFIG;
                    pending_next     = PEND_CONFIG;
                  end
                end
              end
              ssq_pkg::MSG_ACK: begin
                if (item.ack_ok) begin
                  if (item.ack_kind == ssq_pkg::ACK_KIND_CMD) begin
                    if (pending == PEND_CONFIG && item.ack_code == ssq_pkg::ACK_CONFIG) begin
                      result.send_kind = ssq_pkg::SEND_BIND;
                      pending_next     = PEND_BIND;
                    end else if (pending == PEND_BIND &&
                                 item.ack_code == ssq_pkg::ACK_BIND) begin
                      go               = 1'b1;
                      go_target        = ST_CONFIGURED;
                      result.send_kind = ssq_pkg::SEND_STREAM;
                      pending_next     = PEND_STREAM;
                    end else if (pending == PEND_SESSION &&
                                 item.ack_code == ssq_pkg::ACK_SESSION) begin
                      pending_next = PEND_NONE;
                      started_next = 1'b1;
                    end
                  end else if (item.ack_kind == ssq_pkg::ACK_KIND_SYS) begin
                    if (pending == PEND_STREAM && item.ack_code == ssq_pkg::ACK_STREAM) begin
                      go               = 1'b1;
                      go_target        = ST_RUNNING;
                      result.send_kind = ssq_pkg::SEND_SESSION;
                      pending_next     = PEND_SESSION;
                    end
                  end
                end
              end
              ssq_pkg::MSG_NACK: begin
                pending_next = PEND_NONE;
                go           = 1'b1;
                go_target    = ST_ERROR;
              end
              default: ;
            endcase
          end
        end
        default: begin
          if (state == ST_RUNNING)
            result.forward_overlay = 1'b1;
        end
      endcase

      // state change stamps entry time; leaving for a non-running state clears overlay
      if (go && go_target != state) begin
        state_next      = go_target;
        entered_ms_next = now;
        if (go_target != ST_RUNNING)
          result.overlay_clear = 1'b1;
      end
    end

    result.session_out   = session_number_next;
    result.fsm_state_out = state_next;
    result.session_live  = started_next;
  end

  // session state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_RESET;
      pending          <= PEND_NONE;
      session_number   <= '0;
      beat_seq         <= '0;
      entered_ms       <= '0;
      last_hello_ms    <= '0;
      last_resource_ms <= '0;
      last_beat_ms     <= '0;
      started          <= 1'b0;
    end else if (step_en) begin
      state            <= state_next;
      pending          <= pending_next;
      session_number   <= session_number_next;
      beat_seq         <= beat_seq_next;
      entered_ms       <= entered_ms_next;
      last_hello_ms    <= last_hello_ms_next;
      last_resource_ms <= last_resource_ms_next;
      last_beat_ms     <= last_beat_ms_next;
      started          <= started_next;
    end
  end

endmodule

`default_nettype wire

/* sv/session_handshake_sequencer_core.sv */
// Top level of the session handshake sequencer: input register, state
// machine, result register and config registers. Uses ssq_pkg, ssq_cfg, ssq_fsm.
//
//   channel  | direction | handshake             | words
//   ---------+-----------+-----------------------+---------------------------
//   in       | input     | in_valid / in_ready   | tick or decoded message
//   out      | output    | out_valid / out_ready | one result per input word
//   cfg      | input     | cfg_wr_en             | register index and data
//
// Each word waits in the input register and is evaluated against the
// session state as it moves into the result register, which also updates
// the state. One word per cycle is sustained while out_ready stays high.
// A stalled result register holds the input register; in_ready then drops.
// Reset clears the session state and reloads register defaults at once.
`timescale 1ns / 1ps
`default_nettype none

module session_handshake_sequencer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // input words
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [31:0] time_ms,
  input  wire logic [2:0]  msg_class,
  input  wire logic [7:0]  msg_session,
  input  wire logic [1:0]  sys_subtype,
  input  wire logic [1:0]  ack_kind,
  input  wire logic [2:0]  ack_code,
  input  wire logic        ack_ok,
  // result words
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       send_kind,
  output logic [7:0]       session_out,
  output logic [7:0]       beat_seq_out,
  output logic             warm_reset_req,
  output logic             media_enable_pulse,
  output logic             forward_overlay,
  output logic             overlay_clear,
  output logic [2:0]       fsm_state_out,
  output logic             session_live,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  ssq_pkg::cfg_t     cfg;
  ssq_pkg::in_word_t in_word;
  ssq_pkg::in_word_t stage;
  logic              stage_valid;
  logic              stage_move;
  ssq_pkg::result_t  step_result;
  ssq_pkg::result_t  out_word;

  assign in_word = '{req_type:    req_type,
                     time_ms:     time_ms,
                     msg_class:   msg_class,
                     msg_session: msg_session,
                     sys_subtype: sys_subtype,
                     ack_kind:    ack_kind,
                     ack_code:    ack_code,
                     ack_ok:      ack_ok};

  // handshake: stage advances whenever the result register is free or draining
  assign stage_move = stage_valid && (!out_valid || out_ready);
  assign in_ready   = !stage_valid || stage_move;

  ssq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ssq_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step_en (stage_move),
    .item    (stage),
    .result  (step_result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (stage_move) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage <= in_word;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move) begin
      out_word <= step_result;
    end
  end

  assign send_kind          = out_word.send_kind;
  assign session_out        = out_word.session_out;
  assign beat_seq_out       = out_word.beat_seq_out;
  assign warm_reset_req     = out_word.warm_reset_req;
  assign media_enable_pulse = out_word.media_enable_pulse;
  assign forward_overlay    = out_word.forward_overlay;
  assign overlay_clear      = out_word.overlay_clear;
  assign fsm_state_out      = out_word.fsm_state_out;
  assign session_live       = out_word.session_live;

endmodule

`default_nettype wire
